### hdl/cpa_pkg.sv
// ----------------------------------------------------------------------------
// cpa_pkg
// Types and constants shared by the contiguous page allocator modules.
// ----------------------------------------------------------------------------
package cpa_pkg;

	localparam int REGIONS    = 6;
	localparam int PAGES      = 1024;
	localparam int PAGE_BYTES = 4096;

	// Fixed field widths.
	localparam int REGION_W = 3;
	localparam int CNT_W    = 11;
	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 3;
	localparam int FIRST_W  = 10;
	localparam int CFG_IDX_W = 2;

	// Bitmap organization: one RAM row holds WORD_W page bits.
	localparam int WORD_W  = 32;
	localparam int WORD_SH = $clog2(WORD_W);
	localparam int ROWS    = PAGES / WORD_W;
	localparam int ROW_W   = $clog2(ROWS);
	localparam int PAGE_W  = $clog2(PAGES);
	localparam int RUN_W   = CNT_W + 1;
	localparam int PAGE_SH = $clog2(PAGE_BYTES);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_REGION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REGION_PAGES = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FEW    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NORUN  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_LOCKED = 3'd4;

	// Request classes decided by the front end.
	typedef enum logic [1:0] {
		KIND_ALLOC,
		KIND_ZERO,
		KIND_LOCKED
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [CNT_W-1:0] count;
	} cmd_t;

	typedef struct packed {
		logic [REGION_W-1:0] alloc_region;
		logic [ADDR_W-1:0]   region_base;
		logic [CNT_W-1:0]    region_pages;
	} cfg_t;

endpackage

### hdl/cpa_ram.sv
// ----------------------------------------------------------------------------
// cpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cpa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/cpa_front.sv
// ----------------------------------------------------------------------------
// cpa_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module cpa_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cpa_pkg::cfg_t                 cfg,
	input  logic                          push,
	output logic                          full,
	input  logic [cpa_pkg::REGION_W-1:0]  region,
	input  logic [cpa_pkg::CNT_W-1:0]     page_count,
	output logic                          cmd_valid,
	output cpa_pkg::cmd_t                 cmd,
	input  logic                          cmd_take
);

	cpa_pkg::cmd_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    fill_q;
	logic          accept;
	cpa_pkg::cmd_t new_cmd;

	assign full      = (fill_q == 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];
	assign accept    = push && !full;

	// Only the configured region below the region limit is allocatable.
	always_comb begin
		new_cmd.count = page_count;
		priority if (region != cfg.alloc_region || 32'(region) >= cpa_pkg::REGIONS) begin
			new_cmd.kind = cpa_pkg::KIND_LOCKED;
		end else if (page_count == '0) begin
			new_cmd.kind = cpa_pkg::KIND_ZERO;
		end else begin
			new_cmd.kind = cpa_pkg::KIND_ALLOC;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({accept, cmd_take})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### hdl/cpa_back.sv
// ----------------------------------------------------------------------------
// cpa_back
// Runs one request at a time: free count check, first-fit scan of the
// reserved bitmap a row per cycle, read-modify-write of the reserved rows.
// ----------------------------------------------------------------------------
module cpa_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cpa_pkg::cfg_t                 cfg,
	input  logic                          cmd_valid,
	input  cpa_pkg::cmd_t                 cmd,
	output logic                          cmd_take,
	output logic                          empty,
	input  logic                          pop,
	output logic                          granted,
	output logic [cpa_pkg::STATUS_W-1:0]  status,
	output logic [cpa_pkg::ADDR_W-1:0]    page_address,
	output logic [cpa_pkg::FIRST_W-1:0]   first_page
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_RMW_RD = 2'd2;
	localparam logic [1:0] S_RMW_WR = 2'd3;

	logic [1:0]                   state_q;
	logic [cpa_pkg::CNT_W-1:0]    cnt_q;
	logic [cpa_pkg::CNT_W-1:0]    rsv_count_q;
	logic [cpa_pkg::RUN_W-1:0]    run_q;
	logic [cpa_pkg::ROW_W:0]      issue_q;
	logic [cpa_pkg::ROW_W-1:0]    row_s1;
	logic                         rd_v_s1;
	logic                         rvalid_s1;
	logic [cpa_pkg::ROWS-1:0]     row_valid_q;
	logic [cpa_pkg::PAGE_W-1:0]   start_q;
	logic [cpa_pkg::PAGE_W-1:0]   end_page_q;
	logic [cpa_pkg::ROW_W-1:0]    wr_row_q;
	logic                         res_valid_q;

	logic [cpa_pkg::CNT_W-1:0]    eff;
	logic [cpa_pkg::CNT_W-1:0]    free_pages;
	logic [cpa_pkg::CNT_W-1:0]    eff_m1;
	logic [cpa_pkg::ROW_W-1:0]    last_row;
	logic [cpa_pkg::ROW_W-1:0]    raddr;
	logic [cpa_pkg::WORD_W-1:0]   ram_q;
	logic [cpa_pkg::WORD_W-1:0]   rd_word;
	logic [cpa_pkg::WORD_W-1:0]   word_free;
	logic [cpa_pkg::RUN_W-1:0]    run_lane [cpa_pkg::WORD_W];
	logic                         found;
	logic [cpa_pkg::WORD_SH-1:0]  hit_idx;
	logic [cpa_pkg::CNT_W-1:0]    start_calc;
	logic [cpa_pkg::CNT_W-1:0]    end_calc;
	logic [cpa_pkg::WORD_W-1:0]   rsv_mask;
	logic                         ram_we;
	logic                         res_set;
	logic                         issue_ok;
	logic                         scan_last;
	logic                         start_scan;

	// Pages beyond the configured region size are never searched.
	assign eff        = (32'(cfg.region_pages) > cpa_pkg::PAGES) ?
	                    cpa_pkg::CNT_W'(cpa_pkg::PAGES) : cfg.region_pages;
	assign free_pages = (rsv_count_q < eff) ? (eff - rsv_count_q) : '0;
	assign eff_m1     = eff - cpa_pkg::CNT_W'(1);
	assign last_row   = eff_m1[cpa_pkg::PAGE_W-1:cpa_pkg::WORD_SH];

	assign cmd_take   = (state_q == S_IDLE) && cmd_valid && !res_valid_q;
	assign start_scan = cmd_take && (cmd.kind == cpa_pkg::KIND_ALLOC) &&
	                    !(cmd.count > free_pages);
	assign empty      = !res_valid_q;
	assign issue_ok   = (state_q == S_SCAN) && (issue_q <= {1'b0, last_row});
	assign scan_last  = (row_s1 == last_row);

	assign raddr   = (state_q == S_RMW_RD) ? wr_row_q : issue_q[cpa_pkg::ROW_W-1:0];
	// A row never written reads as all pages free.
	assign rd_word = rvalid_s1 ? ram_q : '0;
	assign ram_we  = (state_q == S_RMW_WR);

	cpa_ram #(
		.WIDTH (cpa_pkg::WORD_W),
		.DEPTH (cpa_pkg::ROWS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_row_q),
		.wdata (rd_word | rsv_mask),
		.raddr (raddr),
		.rdata (ram_q)
	);

	// Run length ending at each bit of the row, taken in parallel: the run is
	// broken at the highest blocked bit at or below, else it extends the carried run.
	always_comb begin
		logic [cpa_pkg::PAGE_W-1:0] g;
		logic                       has;
		int                         lb;
		for (int j = 0; j < cpa_pkg::WORD_W; j++) begin
			g = {row_s1, cpa_pkg::WORD_SH'(j)};
			word_free[j] = !rd_word[j] && ({1'b0, g} < eff);
		end
		for (int j = 0; j < cpa_pkg::WORD_W; j++) begin
			has = 1'b0;
			lb  = 0;
			for (int k = 0; k <= j; k++) begin
				if (!word_free[k]) begin
					has = 1'b1;
					lb  = k;
				end
			end
			run_lane[j] = has ? cpa_pkg::RUN_W'(j - lb) : run_q + cpa_pkg::RUN_W'(j + 1);
		end
		found   = 1'b0;
		hit_idx = '0;
		for (int j = 0; j < cpa_pkg::WORD_W; j++) begin
			if (!found && run_lane[j] >= {1'b0, cnt_q}) begin
				found   = 1'b1;
				hit_idx = cpa_pkg::WORD_SH'(j);
			end
		end
		start_calc = cpa_pkg::CNT_W'({row_s1, hit_idx}) + cpa_pkg::CNT_W'(1) - cnt_q;
		end_calc   = cpa_pkg::CNT_W'({row_s1, hit_idx});
	end

	always_comb begin
		logic [cpa_pkg::PAGE_W-1:0] g;
		for (int j = 0; j < cpa_pkg::WORD_W; j++) begin
			g = {wr_row_q, cpa_pkg::WORD_SH'(j)};
			rsv_mask[j] = (g >= start_q) && (g <= end_page_q);
		end
	end

	// A request that goes on to the scan has its result set only when the
	// scan or the write-back finishes.
	assign res_set = (cmd_take && !start_scan) ||
	                 ((state_q == S_SCAN) && rd_v_s1 && !found && scan_last) ||
	                 ((state_q == S_RMW_WR) && (wr_row_q == end_page_q[cpa_pkg::PAGE_W-1:
	                                                                   cpa_pkg::WORD_SH]));

	// Payload registers.
	always_ff @(posedge clk) begin
		rvalid_s1 <= row_valid_q[raddr];
		if (issue_ok) begin
			row_s1 <= issue_q[cpa_pkg::ROW_W-1:0];
		end
		if (cmd_take) begin
			cnt_q        <= cmd.count;
			granted      <= 1'b0;
			page_address <= '0;
			first_page   <= '0;
			unique case (cmd.kind)
				cpa_pkg::KIND_LOCKED: status <= cpa_pkg::ST_LOCKED;
				cpa_pkg::KIND_ZERO:   status <= cpa_pkg::ST_ZERO;
				default:              status <= (cmd.count > free_pages) ?
				                                cpa_pkg::ST_FEW : cpa_pkg::ST_OK;
			endcase
		end
		if (state_q == S_SCAN && rd_v_s1) begin
			if (found) begin
				start_q    <= start_calc[cpa_pkg::PAGE_W-1:0];
				end_page_q <= end_calc[cpa_pkg::PAGE_W-1:0];
				wr_row_q   <= start_calc[cpa_pkg::PAGE_W-1:cpa_pkg::WORD_SH];
			end else if (scan_last) begin
				status <= cpa_pkg::ST_NORUN;
			end
		end
		if (state_q == S_RMW_WR) begin
			wr_row_q <= wr_row_q + cpa_pkg::ROW_W'(1);
			if (res_set) begin
				granted      <= 1'b1;
				status       <= cpa_pkg::ST_OK;
				first_page   <= cpa_pkg::FIRST_W'(start_q);
				page_address <= cfg.region_base +
				                (cpa_pkg::ADDR_W'(start_q) << cpa_pkg::PAGE_SH);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsv_count_q <= '0;
			run_q       <= '0;
			issue_q     <= '0;
			rd_v_s1     <= 1'b0;
			row_valid_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue_ok;
			if (issue_ok) begin
				issue_q <= issue_q + (cpa_pkg::ROW_W + 1)'(1);
			end
			if (res_set) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start_scan) begin
						state_q <= S_SCAN;
						run_q   <= '0;
						issue_q <= '0;
					end
				end
				S_SCAN: begin
					if (rd_v_s1) begin
						run_q <= run_lane[cpa_pkg::WORD_W-1];
						if (found) begin
							state_q <= S_RMW_RD;
						end else if (scan_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_RMW_RD: begin
					state_q <= S_RMW_WR;
				end
				S_RMW_WR: begin
					row_valid_q[wr_row_q] <= 1'b1;
					if (res_set) begin
						state_q     <= S_IDLE;
						rsv_count_q <= rsv_count_q + cnt_q;
					end else begin
						state_q <= S_RMW_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A new request is never started while a result still waits.
	a_take_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> !res_valid_q)
		else $error("request started while result pending");

	// A grant adds exactly the requested count to the reserved total.
	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RMW_WR && res_set) |=> rsv_count_q == $past(rsv_count_q + cnt_q))
		else $error("reserved count not advanced by grant size");

	// The reserved count only changes at the end of a grant.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == S_RMW_WR && res_set) |=> $stable(rsv_count_q))
		else $error("reserved count changed outside a grant");

	// The write-back never walks past the last row of the reserved run.
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RMW_WR) |-> wr_row_q <= end_page_q[cpa_pkg::PAGE_W-1:cpa_pkg::WORD_SH])
		else $error("write-back beyond reserved run");

endmodule

### hdl/contiguous_page_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit contiguous page allocator over one configurable region.
// ----------------------------------------------------------------------------
//  channel   handshake            words carried
//  request   push / full          region, page_count
//  result    empty / pop          granted, status, page_address, first_page
//  config    cfg_we               cfg_index, cfg_data
//
// A request enters a two-entry queue; a failing check sets the result from
// the take alone, with no scan. A grant needs a scan of the bitmap rows
// (one bitmap RAM row read per cycle), then a read and a write of each row
// that the reserved run touches. Reset clears per-row valid flags at once, so
// there is no clearing pass. The back end waits for the result to be popped
// before starting the next request; the queue keeps accepting meanwhile.
module contiguous_page_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [cpa_pkg::REGION_W-1:0]   region,
	input  logic [cpa_pkg::CNT_W-1:0]      page_count,
	output logic                           empty,
	input  logic                           pop,
	output logic                           granted,
	output logic [cpa_pkg::STATUS_W-1:0]   status,
	output logic [cpa_pkg::ADDR_W-1:0]     page_address,
	output logic [cpa_pkg::FIRST_W-1:0]    first_page,
	input  logic                           cfg_we,
	input  logic [cpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpa_pkg::ADDR_W-1:0]     cfg_data
);

	cpa_pkg::cfg_t cfg_q;
	cpa_pkg::cmd_t cmd;
	logic          cmd_valid;
	logic          cmd_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alloc_region <= cpa_pkg::REGION_W'(5);
			cfg_q.region_base  <= '0;
			cfg_q.region_pages <= cpa_pkg::CNT_W'(cpa_pkg::PAGES);
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpa_pkg::CFG_ALLOC_REGION:
					cfg_q.alloc_region <= cfg_data[cpa_pkg::REGION_W-1:0];
				cpa_pkg::CFG_REGION_BASE:
					cfg_q.region_base <= cfg_data;
				cpa_pkg::CFG_REGION_PAGES:
					cfg_q.region_pages <= cfg_data[cpa_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	cpa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.push       (push),
		.full       (full),
		.region     (region),
		.page_count (page_count),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take)
	);

	cpa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take),
		.empty        (empty),
		.pop          (pop),
		.granted      (granted),
		.status       (status),
		.page_address (page_address),
		.first_page   (first_page)
	);

endmodule
